>>> design/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// shared types and constants of the linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOTS   = 1024;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CAP_W   = IDX_W + 1;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 64;
    localparam int SLOT_W  = 10;
    localparam int OCC_W   = 11;
    localparam int CFG_W   = 11;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_REMOVE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        RES_OK       = 2'd0,
        RES_NOTFOUND = 2'd1,
        RES_FULL     = 2'd2,
        RES_ZERO     = 2'd3
    } res_t;

    typedef enum logic [1:0] {
        SL_EMPTY   = 2'd0,
        SL_LIVE    = 2'd1,
        SL_DELETED = 2'd2,
        SL_UNUSED  = 2'd3
    } slot_st_t;

    typedef enum logic [2:0] {
        S_SWEEP,
        S_IDLE,
        S_MOD,
        S_READ,
        S_CHECK,
        S_FIN
    } state_t;

endpackage

>>> design/linear_probe_hash_table.sv
// a result is issued after the home-slot remainder, a read and a check of each probed slot,
// and a finish step; clear and zero-value insert go straight to the finish step
// one item at a time: the next item is accepted only once the result is issued, the pace
// set by the remainder unit (one key bit per cycle)
// clear, a capacity write and reset start a sweep over every slot of the status
// ram, during which no item is accepted; reset sets capacity to 1024, table empty
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open addressing hash map of 64-bit keys with linear probing over slot rams
// ----------------------------------------------------------------------------
module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [10:0]  cfg_data,   // capacity
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,    // key[63:0], value[127:64]
    input  logic [1:0]   s_tuser,    // cmd
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [87:0]  m_tdata,    // found_value[63:0], slot[73:64], occupancy[84:74], zero
    output logic [1:0]   m_tuser     // status
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] cap_reg, cap_next;
    logic [CAP_W-1:0] cap_eff;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [OCC_W-1:0] live_reg, live_next;

    cmd_t             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CAP_W-1:0] n_reg, n_next;
    logic             hit_reg, hit_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_at_reg, free_at_next;
    logic [VAL_W-1:0] fval_reg, fval_next;

    logic             mv_reg, mv_next;
    res_t             ms_reg, ms_next;
    logic [VAL_W-1:0] mf_reg, mf_next;
    logic [SLOT_W-1:0] msl_reg, msl_next;
    logic [OCC_W-1:0] mo_reg, mo_next;

    logic             mod_start;
    logic             mod_done;
    logic [IDX_W-1:0] mod_rem;

    logic                   kv_we;
    logic [IDX_W-1:0]       kv_addr;
    logic [KEY_W+VAL_W-1:0] kv_rd;
    logic                   st_we;
    logic [IDX_W-1:0]       st_addr;
    slot_st_t               st_wd;
    logic [1:0]             st_rd;

    logic             s_acc, cfg_acc, fin_go, chk_live, chk_match;
    logic             chk_end;
    logic [CAP_W-1:0] n_inc, idx_inc;
    logic             quick;

    always_comb
    begin
        cap_eff = cap_reg;
        if (cap_reg == '0)
            cap_eff = CAP_W'(1);
        else if (cap_reg > CAP_W'(SLOTS))
            cap_eff = CAP_W'(SLOTS);
    end

    assign cfg_ready = (state_reg == S_IDLE) && !mv_reg;
    assign cfg_acc   = cfg_valid && cfg_ready;
    // a capacity write takes the cycle, so no item is taken beside it
    assign s_tready  = (state_reg == S_IDLE) && !cfg_acc;
    assign s_acc     = s_tvalid && s_tready;
    assign fin_go    = (state_reg == S_FIN) && (!mv_reg || m_tready);
    assign quick     = (cmd_t'(s_tuser) == CMD_CLEAR) ||
                       ((cmd_t'(s_tuser) == CMD_INSERT) && (s_tdata[127:64] == '0));

    assign chk_live  = (slot_st_t'(st_rd) == SL_LIVE);
    assign chk_match = chk_live && (kv_rd[KEY_W-1:0] == key_reg);
    assign n_inc     = n_reg + 1'b1;
    assign idx_inc   = {1'b0, idx_reg} + 1'b1;
    assign chk_end   = chk_match || (slot_st_t'(st_rd) == SL_EMPTY) || (n_inc == cap_eff);

    assign mod_start = s_acc && !quick;

    lpht_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (s_tdata[63:0]),
        .cap   (cap_eff),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    lpht_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(SLOTS)) u_kv (
        .clk   (clk),
        .we    (kv_we),
        .addr  (kv_addr),
        .wdata ({val_reg, key_reg}),
        .rdata (kv_rd)
    );

    lpht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_st (
        .clk   (clk),
        .we    (st_we),
        .addr  (st_addr),
        .wdata (st_wd),
        .rdata (st_rd)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SWEEP: if (clr_reg == '1) state_next = S_IDLE;
            S_IDLE:
            begin
                if (cfg_acc)
                    state_next = S_SWEEP;
                else if (s_acc)
                    state_next = quick ? S_FIN : S_MOD;
            end
            S_MOD:   if (mod_done) state_next = S_READ;
            S_READ:  state_next = S_CHECK;
            S_CHECK: state_next = chk_end ? S_FIN : S_READ;
            S_FIN:
            begin
                if (fin_go)
                    state_next = (cmd_reg == CMD_CLEAR) ? S_SWEEP : S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cap_next     = cap_reg;
        clr_next     = clr_reg;
        live_next    = live_reg;
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        hit_next     = hit_reg;
        free_next    = free_reg;
        free_at_next = free_at_reg;
        fval_next    = fval_reg;
        mv_next      = mv_reg && !m_tready;
        ms_next      = ms_reg;
        mf_next      = mf_reg;
        msl_next     = msl_reg;
        mo_next      = mo_reg;
        kv_we        = 1'b0;
        kv_addr      = idx_reg;
        st_we        = 1'b0;
        st_addr      = idx_reg;
        st_wd        = SL_EMPTY;

        unique case (state_reg)
            S_SWEEP:
            begin
                st_we    = 1'b1;
                st_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            S_IDLE:
            begin
                clr_next = '0;
                if (cfg_acc)
                begin
                    cap_next  = cfg_data;
                    live_next = '0;
                end
                else if (s_acc)
                begin
                    cmd_next  = cmd_t'(s_tuser);
                    key_next  = s_tdata[63:0];
                    val_next  = s_tdata[127:64];
                    hit_next  = 1'b0;
                    free_next = 1'b0;
                    n_next    = '0;
                end
            end
            S_MOD:   if (mod_done) idx_next = mod_rem;
            S_READ:  ;
            S_CHECK:
            begin
                if (chk_match)
                begin
                    hit_next  = 1'b1;
                    fval_next = kv_rd[KEY_W+VAL_W-1:KEY_W];
                end
                else
                begin
                    if (!chk_live && !free_reg)
                    begin
                        free_next    = 1'b1;
                        free_at_next = idx_reg;
                    end
                    n_next   = n_inc;
                    idx_next = (idx_inc == cap_eff) ? '0 : idx_inc[IDX_W-1:0];
                end
                if (chk_end && !chk_match)
                    idx_next = idx_reg;
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    mv_next  = 1'b1;
                    ms_next  = RES_OK;
                    mf_next  = '0;
                    msl_next = '0;
                    case (cmd_reg)
                        CMD_CLEAR:
                        begin
                            live_next = '0;
                            clr_next  = '0;
                        end
                        CMD_INSERT:
                        begin
                            if (val_reg == '0)
                                ms_next = RES_ZERO;
                            else if (hit_reg)
                            begin
                                kv_we    = 1'b1;
                                msl_next = SLOT_W'(idx_reg);
                            end
                            else if (free_reg)
                            begin
                                kv_we     = 1'b1;
                                kv_addr   = free_at_reg;
                                st_we     = 1'b1;
                                st_addr   = free_at_reg;
                                st_wd     = SL_LIVE;
                                live_next = live_reg + 1'b1;
                                msl_next  = SLOT_W'(free_at_reg);
                            end
                            else
                                ms_next = RES_FULL;
                        end
                        default:
                        begin
                            if (hit_reg)
                            begin
                                mf_next  = fval_reg;
                                msl_next = SLOT_W'(idx_reg);
                                if (cmd_reg == CMD_REMOVE)
                                begin
                                    st_we = 1'b1;
                                    st_wd = SL_DELETED;
                                    if (live_reg != '0)
                                        live_next = live_reg - 1'b1;
                                end
                            end
                            else
                                ms_next = RES_NOTFOUND;
                        end
                    endcase
                    mo_next = live_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SWEEP;
            cap_reg   <= CFG_W'(SLOTS);
            clr_reg   <= '0;
            live_reg  <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cap_reg   <= cap_next;
            clr_reg   <= clr_next;
            live_reg  <= live_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        val_reg     <= val_next;
        idx_reg     <= idx_next;
        n_reg       <= n_next;
        hit_reg     <= hit_next;
        free_reg    <= free_next;
        free_at_reg <= free_at_next;
        fval_reg    <= fval_next;
        ms_reg      <= ms_next;
        mf_reg      <= mf_next;
        msl_reg     <= msl_next;
        mo_reg      <= mo_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tuser  = ms_reg;
    assign m_tdata  = {3'b000, mo_reg, msl_reg, mf_reg};

`ifndef SYNTHESIS
    a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP) |-> !s_tready && !cfg_ready)
        else $error("item accepted during status sweep");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (mo_reg <= OCC_W'(SLOTS)))
        else $error("occupancy above slot count");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> ({1'b0, mod_rem} < cap_eff))
        else $error("home slot beyond capacity");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && mv_reg && !m_tready) |=> (state_reg == S_FIN))
        else $error("result overwritten before delivery");
`endif

endmodule

>>> design/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// bit-serial remainder of a 64-bit key by the capacity in use, one bit a cycle
// ----------------------------------------------------------------------------
module lpht_mod
    import lpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [KEY_W-1:0] key,
    input  logic [CAP_W-1:0] cap,
    output logic             done,
    output logic [IDX_W-1:0] rem
);

    logic                     busy_reg, busy_next;
    logic [$clog2(KEY_W)-1:0] cnt_reg, cnt_next;
    logic [KEY_W-1:0]         sh_reg, sh_next;
    logic [CAP_W-1:0]         rem_reg, rem_next;
    logic [CAP_W-1:0]         div_reg, div_next;
    logic                     done_reg, done_next;
    logic [CAP_W:0]           trial;

    always_comb
    begin
        trial     = {rem_reg, sh_reg[KEY_W-1]};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            sh_next   = key;
            rem_next  = '0;
            div_next  = cap;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                trial = trial - {1'b0, div_reg};
            rem_next = trial[CAP_W-1:0];
            sh_next  = {sh_reg[KEY_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == '1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[IDX_W-1:0];

endmodule

>>> design/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// single-port synchronous ram, registered read
// ----------------------------------------------------------------------------
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the linear probing hash table against a behavioral model of the
// store, over directed corner cases and random operation mixes at several
// capacities, with random stalls on both streams
// ----------------------------------------------------------------------------
module tb_top
    import lpht_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 40000;
    localparam int LONG_HOLD  = 600;

    typedef struct {
        res_t        status;
        logic [63:0] found_value;
        logic [9:0]  slot;
        logic [10:0] occupancy;
    } table_result_t;

    class table_scoreboard;
        logic [63:0]   keys [SLOTS];
        logic [63:0]   values [SLOTS];
        slot_st_t      slot_state [SLOTS];
        int            live;
        int            capacity;
        table_result_t expected_q [$];
        int            errors;

        function void wipe();
            for (int i = 0; i < SLOTS; i++)
                slot_state[i] = SL_EMPTY;
            live = 0;
        endfunction

        function void set_capacity(logic [10:0] c);
            capacity = c;
            wipe();
        endfunction

        function int slots_in_use();
            int c;
            c = capacity;
            if (c == 0)
                c = 1;
            if (c > SLOTS)
                c = SLOTS;
            return c;
        endfunction

        // walks the chain from the home slot; returns 1 on a live key match
        function bit walk_chain(logic [63:0] key, output int hit, output bit has_free,
                                output int free_at);
            int c;
            int idx;
            c = slots_in_use();
            idx = int'(key % 64'(c));
            hit = 0;
            has_free = 0;
            free_at = 0;
            for (int n = 0; n < c; n++)
            begin
                if (slot_state[idx] == SL_LIVE)
                begin
                    if (keys[idx] == key)
                    begin
                        hit = idx;
                        return 1;
                    end
                end
                else
                begin
                    if (!has_free)
                    begin
                        has_free = 1;
                        free_at = idx;
                    end
                    if (slot_state[idx] == SL_EMPTY)
                        return 0;
                end
                idx++;
                if (idx >= c)
                    idx = 0;
            end
            return 0;
        endfunction

        function void note_input(cmd_t cmd, logic [63:0] key, logic [63:0] value);
            table_result_t r;
            int            hit;
            int            free_at;
            bit            has_free;
            bit            found;
            r.status = RES_OK;
            r.found_value = '0;
            r.slot = '0;
            if (cmd == CMD_CLEAR)
                wipe();
            else if (cmd == CMD_INSERT)
            begin
                if (value == 0)
                    r.status = RES_ZERO;
                else
                begin
                    found = walk_chain(key, hit, has_free, free_at);
                    if (found)
                    begin
                        values[hit] = value;
                        r.slot = hit[9:0];
                    end
                    else if (has_free)
                    begin
                        keys[free_at] = key;
                        values[free_at] = value;
                        slot_state[free_at] = SL_LIVE;
                        live++;
                        r.slot = free_at[9:0];
                    end
                    else
                        r.status = RES_FULL;
                end
            end
            else
            begin
                found = walk_chain(key, hit, has_free, free_at);
                if (found)
                begin
                    r.found_value = values[hit];
                    r.slot = hit[9:0];
                    if (cmd == CMD_REMOVE)
                    begin
                        slot_state[hit] = SL_DELETED;
                        if (live > 0)
                            live--;
                    end
                end
                else
                    r.status = RES_NOTFOUND;
            end
            r.occupancy = live[10:0];
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] status, logic [87:0] data);
            table_result_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result: status %0d data %h", status, data);
                return;
            end
            e = expected_q.pop_front();
            if (status !== e.status || data[63:0] !== e.found_value ||
                data[73:64] !== e.slot || data[84:74] !== e.occupancy)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp st %0d val %h slot %0d occ %0d,",
                             e.status, e.found_value, e.slot, e.occupancy,
                             " got st %0d val %h slot %0d occ %0d",
                             status, data[63:0], data[73:64], data[84:74]);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [10:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;    // key[63:0], value[127:64]
    logic [1:0]   s_tuser;    // cmd
    logic         m_tvalid;
    logic         m_tready;
    logic [87:0]  m_tdata;    // found_value[63:0], slot[73:64], occupancy[84:74], zero
    logic [1:0]   m_tuser;    // status

    table_scoreboard sb;
    bit              quiet;
    int              hold_cycles;
    int              idle_count;
    logic [63:0]     key_pool [$];

    linear_probe_hash_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                stall = $urandom_range(1, 8) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_op(cmd_t cmd, logic [63:0] key, logic [63:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {value, key};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(cmd, key, value);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(logic [10:0] c);
        drain();
        repeat (8) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= c;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_capacity(c);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // pool of keys reused within a phase so hits, collisions and full chains occur
    task automatic fill_pool(int n);
        key_pool.delete();
        for (int i = 0; i < n; i++)
        begin
            if (i % 3 == 0)
                key_pool.push_back(rand64());
            else
                key_pool.push_back(64'($urandom_range(0, 300)));
        end
    endtask

    task automatic random_op();
        int          sel;
        cmd_t        cmd;
        logic [63:0] key;
        logic [63:0] value;
        sel = $urandom_range(0, 99);
        if (sel < 45)
            cmd = CMD_INSERT;
        else if (sel < 70)
            cmd = CMD_LOOKUP;
        else if (sel < 98)
            cmd = CMD_REMOVE;
        else
            cmd = CMD_CLEAR;
        if ($urandom_range(0, 9) < 7)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else
            key = rand64();
        value = ($urandom_range(0, 19) == 0) ? 64'd0 : rand64();
        send_op(cmd, key, value);
    endtask

    initial
    begin
        int caps [10] = '{1, 0, 2, 3, 7, 16, 64, 1024, 2047, 5};
        sb = new();
        sb.set_capacity(11'd1024);
        sb.errors = 0;
        quiet = 0;
        hold_cycles = 0;
        idle_count = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_INSERT;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // corner cases at the reset capacity
        send_op(CMD_INSERT, 64'd0, '1);
        send_op(CMD_INSERT, '1, 64'd1);
        send_op(CMD_INSERT, 64'd5, 64'd0);
        send_op(CMD_LOOKUP, 64'd0, '0);
        send_op(CMD_LOOKUP, '1, '0);
        send_op(CMD_LOOKUP, 64'd77, '0);
        send_op(CMD_INSERT, 64'd0, 64'h5555_aaaa_5555_aaaa);
        send_op(CMD_INSERT, 64'd1024, 64'h1234);
        send_op(CMD_REMOVE, 64'd0, '0);
        send_op(CMD_REMOVE, 64'd0, '0);
        send_op(CMD_LOOKUP, 64'd1024, '0);
        send_op(CMD_INSERT, 64'd2048, 64'haaaa_5555_aaaa_5555);
        send_op(CMD_CLEAR, '0, '0);
        send_op(CMD_LOOKUP, '1, '0);
        // single slot: fill, overflow, reuse a deleted slot
        write_capacity(11'd1);
        send_op(CMD_INSERT, 64'd5, 64'd9);
        send_op(CMD_INSERT, 64'd6, 64'd10);
        send_op(CMD_REMOVE, 64'd5, '0);
        send_op(CMD_INSERT, 64'd6, 64'd11);
        send_op(CMD_LOOKUP, 64'd6, '0);

        for (int p = 0; p < 10; p++)
        begin
            int c;
            write_capacity(caps[p][10:0]);
            c = sb.slots_in_use();
            fill_pool((c * 2 > 40) ? 40 : c * 2 + 1);
            if (p == 9)
                quiet = 1;
            for (int i = 0; i < 130; i++)
            begin
                if (p == 2 && i == 40)
                    hold_cycles = LONG_HOLD;
                if (p == 4 && i == 60)
                    drain();
                random_op();
            end
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> filelist.f
design/lpht_pkg.sv
design/lpht_mod.sv
design/lpht_ram.sv
design/linear_probe_hash_table.sv
test/tb_top.sv
